// File: rtl/nfa_bit_parallel_matcher_unit_assert.svh
// ----------------------------------------------------------------------------
// NFA matcher assertion macros
// Shared property forms for the matcher's concurrent checks. The checks
// sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NFA_BIT_PARALLEL_MATCHER_UNIT_ASSERT_SVH
`define NFA_BIT_PARALLEL_MATCHER_UNIT_ASSERT_SVH

// cond in a cycle requires expr in the same cycle
`define NBPM_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// cond in a cycle requires expr in the next cycle
`define NBPM_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: rtl/nbpm_pkg.sv
// ----------------------------------------------------------------------------
// NFA matcher package
// Sizes, stream field layout, command encoding and shared types.
// ----------------------------------------------------------------------------
package nbpm_pkg;

    localparam int NUM_STATES  = 32;
    localparam int NUM_SYMBOLS = 128;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int SYM_W       = $clog2(NUM_SYMBOLS);

    // Fixed request field widths
    localparam int REQ_W         = 3;
    localparam int SYM_FIELD_W   = 7;
    localparam int STATE_FIELD_W = 5;
    localparam int ACTIVE_W      = 32;

    // Input stream layout
    localparam int SYM_LSB     = 0;
    localparam int SRC_LSB     = SYM_LSB + SYM_FIELD_W;
    localparam int DST_LSB     = SRC_LSB + STATE_FIELD_W;
    localparam int FLAG_BIT    = DST_LSB + STATE_FIELD_W;
    localparam int IN_DATA_W   = 24;
    localparam int IN_USER_W   = REQ_W;

    // Output stream layout
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_PAD_W   = OUT_DATA_W - ACTIVE_W - 1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [REQ_W-1:0] REQ_STEP    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD_ALL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_ACC = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESTART = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_STEP,
        OP_ADD,
        OP_ADD_ALL,
        OP_SET_ACC,
        OP_RESTART
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               sym_ok;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic               flag;
        logic               last;
    } nbpm_cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_ADD
    } back_state_t;

    typedef struct packed {
        logic clearing;
        logic busy;
        logic pop;
    } nbpm_back_status_t;

endpackage

// File: rtl/nbpm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nbpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/nbpm_front.sv
// ----------------------------------------------------------------------------
// NFA matcher front end
// Takes requests from the input stream, range-checks the fields and turns
// each request into an internal command for the queue.
// ----------------------------------------------------------------------------
module nbpm_front
    import nbpm_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    input  logic                 q_full,
    input  logic                 clearing,
    output logic                 push,
    output nbpm_cmd_t            cmd
);

    logic [SYM_FIELD_W-1:0]   sym_f;
    logic [STATE_FIELD_W-1:0] src_f;
    logic [STATE_FIELD_W-1:0] dst_f;
    logic                     sym_ok;
    logic                     src_ok;
    logic                     dst_ok;

    assign sym_f  = s_axis_tdata[SYM_LSB +: SYM_FIELD_W];
    assign src_f  = s_axis_tdata[SRC_LSB +: STATE_FIELD_W];
    assign dst_f  = s_axis_tdata[DST_LSB +: STATE_FIELD_W];

    assign sym_ok = (32'(sym_f) < NUM_SYMBOLS);
    assign src_ok = (32'(src_f) < NUM_STATES);
    assign dst_ok = (32'(dst_f) < NUM_STATES);

    // Hold off requests while the transition store is being cleared
    assign s_axis_tready = !q_full && !clearing;
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd.sym_ok = sym_ok;
        cmd.sym    = SYM_W'(sym_f);
        cmd.src    = STATE_W'(src_f);
        cmd.dst    = STATE_W'(dst_f);
        cmd.flag   = s_axis_tdata[FLAG_BIT];
        cmd.last   = 1'b0;
        case (s_axis_tuser)
            REQ_STEP:
            begin
                cmd.op   = OP_STEP;
                cmd.last = s_axis_tlast;
            end
            REQ_ADD:     cmd.op = (sym_ok && src_ok && dst_ok) ? OP_ADD : OP_NOP;
            REQ_ADD_ALL: cmd.op = (src_ok && dst_ok) ? OP_ADD_ALL : OP_NOP;
            REQ_SET_ACC: cmd.op = src_ok ? OP_SET_ACC : OP_NOP;
            REQ_RESTART: cmd.op = OP_RESTART;
            default:     cmd.op = OP_NOP;
        endcase
    end

endmodule

// File: rtl/nbpm_queue.sv
// ----------------------------------------------------------------------------
// NFA matcher command queue
// Short FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module nbpm_queue
    import nbpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  nbpm_cmd_t cmd_in,
    input  logic      pop,
    output nbpm_cmd_t cmd_out,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    nbpm_cmd_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: rtl/nbpm_back.sv
// ----------------------------------------------------------------------------
// NFA matcher back end
// Runs queued commands against the transition store, the accepting marks and
// the active set, and holds each result in the output register.
// The store is one RAM per source state, addressed by symbol; transitions
// added on every symbol live in a per-state register that is merged on a step.
// ----------------------------------------------------------------------------
module nbpm_back
    import nbpm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  nbpm_cmd_t           q_cmd,
    input  logic                q_empty,
    output nbpm_back_status_t   status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                res_accepting,
    output logic [ACTIVE_W-1:0] res_active,
    output logic                res_done
);

    back_state_t state_reg;
    back_state_t state_next;

    nbpm_cmd_t             cmd_reg;
    logic [SYM_W-1:0]      clr_addr_reg;
    logic [NUM_STATES-1:0] active_reg;
    logic [NUM_STATES-1:0] active_next;
    logic [NUM_STATES-1:0] marks_reg;
    logic [NUM_STATES-1:0] marks_next;
    logic [NUM_STATES-1:0] all_reg [NUM_STATES];

    logic                  out_valid_reg;
    logic                  out_accepting_reg;
    logic [ACTIVE_W-1:0]   out_active_reg;
    logic                  out_done_reg;

    logic                  out_free;
    logic                  pop;
    logic                  load_out;
    logic                  done;
    logic [NUM_STATES-1:0] lane_we;
    logic [SYM_W-1:0]      wr_addr;
    logic [NUM_STATES-1:0] wr_data;
    logic [SYM_W-1:0]      rd_addr;
    logic [NUM_STATES-1:0] rd_data [NUM_STATES];
    logic [NUM_STATES-1:0] step_union;
    logic [NUM_STATES-1:0] dst_bit;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign rd_addr  = (state_reg == ST_IDLE) ? q_cmd.sym : cmd_reg.sym;
    assign dst_bit  = NUM_STATES'(1) << cmd_reg.dst;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.busy     = (state_reg == ST_STEP) || (state_reg == ST_ADD);
    assign status.pop      = pop;

    for (genvar s = 0; s < NUM_STATES; s++)
    begin : g_lane
        nbpm_ram #(
            .WIDTH (NUM_STATES),
            .DEPTH (NUM_SYMBOLS)
        ) u_ram (
            .clk   (clk),
            .we    (lane_we[s]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .raddr (rd_addr),
            .rdata (rd_data[s])
        );
    end

    // Union of the target sets of all active states
    always_comb
    begin
        step_union = '0;
        for (int s = 0; s < NUM_STATES; s++)
        begin
            if (active_reg[s])
            begin
                step_union = step_union | rd_data[s] | all_reg[s];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == SYM_W'(NUM_SYMBOLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop && q_cmd.op == OP_STEP)
                begin
                    state_next = ST_STEP;
                end
                else if (pop && q_cmd.op == OP_ADD)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_STEP: state_next = ST_IDLE;
            ST_ADD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        marks_next  = marks_reg;
        load_out    = 1'b0;
        done        = 1'b0;
        lane_we     = '0;
        wr_addr     = clr_addr_reg;
        wr_data     = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                lane_we = '1;
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (q_cmd.op)
                        OP_STEP:    load_out = 1'b0;
                        OP_ADD:     load_out = 1'b0;
                        OP_SET_ACC:
                        begin
                            marks_next[q_cmd.src] = q_cmd.flag;
                            load_out = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            active_next = NUM_STATES'(1);
                            load_out = 1'b1;
                        end
                        default:    load_out = 1'b1;
                    endcase
                end
            end
            ST_STEP:
            begin
                active_next = cmd_reg.sym_ok ? step_union : '0;
                done        = cmd_reg.last;
                load_out    = 1'b1;
            end
            ST_ADD:
            begin
                lane_we[cmd_reg.src] = 1'b1;
                wr_addr  = cmd_reg.sym;
                wr_data  = rd_data[cmd_reg.src] | dst_bit;
                load_out = 1'b1;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            active_reg    <= NUM_STATES'(1);
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_STATES; s++)
            begin
                all_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            marks_reg  <= marks_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (pop && q_cmd.op == OP_ADD_ALL)
            begin
                all_reg[q_cmd.src] <= all_reg[q_cmd.src] | (NUM_STATES'(1) << q_cmd.dst);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (load_out)
        begin
            out_accepting_reg <= |(active_next & marks_next);
            out_active_reg    <= ACTIVE_W'(active_next);
            out_done_reg      <= done;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign res_accepting = out_accepting_reg;
    assign res_active    = out_active_reg;
    assign res_done      = out_done_reg;

endmodule

// File: rtl/nfa_bit_parallel_matcher_unit.sv
// ----------------------------------------------------------------------------
// NFA bit-parallel matcher
// Builds and runs an NFA without epsilon moves over a stream of requests.
// ----------------------------------------------------------------------------
// Each request returns one result: the active state set after the request and
// whether it holds an accepting state. Restart, set-accepting, add-on-every-
// symbol and unknown requests finish in the back end's idle state; step and
// add-transition requests also pass through ST_STEP or ST_ADD, for the
// registered read of the transition RAMs (one RAM per state, one row per
// symbol, all read together on a step). A two-entry command queue lets requests
// arrive while a result waits at the output. After reset the RAMs are cleared,
// one symbol row a cycle over all NUM_SYMBOLS (128) rows, taking no requests.
`include "nfa_bit_parallel_matcher_unit_assert.svh"

module nfa_bit_parallel_matcher_unit
    import nbpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [6:0] symbol, [11:7] state_index, [16:12] target_state, [17] accept_flag
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] req_type
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] accepting, [32:1] active_set
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    nbpm_cmd_t           front_cmd;
    nbpm_cmd_t           q_cmd;
    logic                push;
    logic                q_empty;
    logic                q_full;
    nbpm_back_status_t   back_status;
    logic                res_accepting;
    logic [ACTIVE_W-1:0] res_active;

    nbpm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .clearing      (back_status.clearing),
        .push          (push),
        .cmd           (front_cmd)
    );

    nbpm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (back_status.pop),
        .cmd_out (q_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    nbpm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_cmd         (q_cmd),
        .q_empty       (q_empty),
        .status        (back_status),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .res_accepting (res_accepting),
        .res_active    (res_active),
        .res_done      (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_active, res_accepting};

    `NBPM_ASSERT_NOW(a_pop_not_empty, back_status.pop, !q_empty, "pop from empty queue")
    `NBPM_ASSERT_NOW(a_no_pop_clear, back_status.clearing, !back_status.pop,
        "command taken during clear pass")
    `NBPM_ASSERT_NOW(a_busy_out_free, back_status.busy, !m_axis_tvalid,
        "output register occupied while a command is in flight")
    `NBPM_ASSERT_NEXT(a_step_busy, back_status.pop && q_cmd.op == OP_STEP,
        back_status.busy, "step did not enter its read cycle")

endmodule
